>>> rtl/core/blr_pkg.sv
// Shared widths, reset values and controller/datapath interface types for the line rasterizer.
`default_nettype none
package blr_pkg;

  localparam int COORD_W  = 6;
  localparam int PIXEL_W  = 56;
  localparam int ADDR_W   = 12;
  localparam int WIDTH_W  = 7;
  localparam int ERR_W    = COORD_W + 3;
  localparam int PROD_W   = COORD_W + WIDTH_W;
  localparam int S_DATA_W = 4 * COORD_W + PIXEL_W;
  localparam int M_DATA_W = 2 * COORD_W + ADDR_W + PIXEL_W;

  localparam logic [WIDTH_W-1:0] CANVAS_WIDTH_RESET = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } blr_status_t;

endpackage
`default_nettype wire

>>> rtl/core/blr_ctrl.sv
// Controller state machine: accepts a line command and paces the pixel stepper.
`default_nettype none
module blr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire blr_pkg::blr_status_t status,
  output blr_pkg::blr_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/blr_datapath.sv
// Datapath: line setup, Bresenham stepper, address multiply and output register.
`default_nettype none
module blr_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire blr_pkg::blr_cmd_t                   cmd,
  output blr_pkg::blr_status_t                     status,
  input  wire logic [blr_pkg::S_DATA_W-1:0]        s_tdata,
  input  wire logic [blr_pkg::WIDTH_W-1:0]         canvas_width,
  input  wire logic                                m_tready,
  output logic                                     m_tvalid,
  output logic [blr_pkg::M_DATA_W-1:0]             m_tdata,
  output logic                                     m_tlast
);

  localparam int CW = blr_pkg::COORD_W;
  localparam int EW = blr_pkg::ERR_W;

  // Setup from the incoming command.
  logic [CW-1:0] x0, y0, x1, y1;
  logic [CW-1:0] adx, ady, sx0, sy0, sx1, sy1;
  logic          shallow_c, swap_c;
  logic [CW-1:0] major_c, minor_c;
  logic          neg_c;

  always_comb begin
    x0 = s_tdata[CW-1:0];
    y0 = s_tdata[2*CW-1:CW];
    x1 = s_tdata[3*CW-1:2*CW];
    y1 = s_tdata[4*CW-1:3*CW];
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    shallow_c = (ady < adx);
    swap_c = shallow_c ? (x0 > x1) : (y0 > y1);
    sx0 = swap_c ? x1 : x0;
    sy0 = swap_c ? y1 : y0;
    sx1 = swap_c ? x0 : x1;
    sy1 = swap_c ? y0 : y1;
    major_c = shallow_c ? adx : ady;
    minor_c = shallow_c ? ady : adx;
    neg_c   = shallow_c ? (sy1 < sy0) : (sx1 < sx0);
  end

  // Stepper state.
  logic [CW-1:0]                 pos_major, pos_minor, major_len, minor_d, remain;
  logic                          shallow, neg;
  logic signed [EW-1:0]          d;
  logic [blr_pkg::PIXEL_W-1:0]   pix;

  logic signed [EW-1:0] two_minor, d_up, d_flat, d_init;
  logic [CW-1:0]        plot_x_c, plot_y_c;
  logic [blr_pkg::PROD_W-1:0] prod;
  logic [blr_pkg::ADDR_W-1:0] addr_c;

  always_comb begin
    two_minor = $signed({2'b00, minor_d, 1'b0});
    d_up      = two_minor - $signed({2'b00, major_len, 1'b0});
    d_flat    = two_minor;
    d_init    = $signed({2'b00, minor_c, 1'b0}) - $signed({3'b000, major_c});
    plot_x_c  = shallow ? pos_major : pos_minor;
    plot_y_c  = shallow ? pos_minor : pos_major;
    prod      = plot_y_c * canvas_width;
    addr_c    = prod[blr_pkg::ADDR_W-1:0] + {{(blr_pkg::ADDR_W-CW){1'b0}}, plot_x_c};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shallow   <= shallow_c;
      neg       <= neg_c;
      major_len <= major_c;
      minor_d   <= minor_c;
      remain    <= major_c;
      pos_major <= shallow_c ? sx0 : sy0;
      pos_minor <= shallow_c ? sy0 : sx0;
      d         <= d_init;
      pix       <= s_tdata[blr_pkg::S_DATA_W-1:4*CW];
    end else if (cmd.step) begin
      // The minor axis moves only while the error term is strictly positive.
      if (d > 0) begin
        pos_minor <= neg ? pos_minor - 1'b1 : pos_minor + 1'b1;
        d         <= d + d_up;
      end else begin
        d         <= d + d_flat;
      end
      pos_major <= pos_major + 1'b1;
      remain    <= remain - 1'b1;
    end
  end

  // Output register; the stepper advances only into a free or draining slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      m_tdata <= {pix, addr_c, plot_y_c, plot_x_c};
      m_tlast <= (remain == '0);
    end
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign status.last     = (remain == '0);

endmodule
`default_nettype wire

>>> rtl/core/bresenham_line_rasterizer_unit.sv
// Top level of the Bresenham line rasterizer: canvas width register, controller and datapath.
//
//  channel  | direction | signals                          | contents
//  ---------+-----------+----------------------------------+------------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata[79:0]  | one line command per transaction
//  m_*      | out       | m_tvalid m_tready m_tdata[79:0]  | one pixel write per transaction
//           |           | m_tlast                          | final pixel of the line
//  cfg_*    | in        | cfg_valid cfg_ready cfg_data[6:0]| canvas width register write
//
// A command is taken, then the stepper produces one pixel per cycle while the output
// register is free or draining, for a line of N pixels (N = 1 + the longer axis span,
// at most 64). The stepper stalls whenever the output register is full and not being taken.
// The next command is accepted as soon as the final pixel sits in the output register.
// rst is synchronous and active high; canvas width resets to 64. cfg_ready is always high.
`default_nettype none
module bresenham_line_rasterizer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], pixel_value[79:24]
  input  wire logic [blr_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // plot_x[5:0], plot_y[11:6], write_address[23:12], pixel_out[79:24]
  output logic [blr_pkg::M_DATA_W-1:0]       m_tdata,
  output logic                               m_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [blr_pkg::WIDTH_W-1:0]   cfg_data
);

  logic [blr_pkg::WIDTH_W-1:0] canvas_width;
  blr_pkg::blr_cmd_t           cmd;
  blr_pkg::blr_status_t        status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= blr_pkg::CANVAS_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      canvas_width <= cfg_data;
    end
  end

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  blr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .s_tdata      (s_tdata),
    .canvas_width (canvas_width),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

`ifndef ASSERT_OFF
  // Accepting a command always puts the block busy stepping the line, so s_tready drops.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while the previous one was still being stepped");

  // The address on the output matches the coordinates it carries while the canvas width is unchanged.
  a_addr_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:12] ==
      12'(12'(m_tdata[11:6]) * 12'(canvas_width) + 12'(m_tdata[5:0])))
    else $error("write address does not match plot coordinates");
`endif

endmodule
`default_nettype wire
